@@ hw/rtl/rbgr_pkg.sv @@
// Shared types and constants for the rotated bitmap glyph renderer.
// Holds command codes, register indexes, rotation codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package rbgr_pkg;

	// Default sizes handed to the top level
	localparam int FONT_BYTES_DEF = 4096;
	localparam int MAX_WIDTH_DEF  = 32;
	localparam int MAX_HEIGHT_DEF = 32;

	// Font layout offsets
	localparam logic [15:0] ADDR_ENABLE = 16'd0;
	localparam logic [15:0] ADDR_HEIGHT = 16'd6;
	localparam logic [15:0] ADDR_TABLE  = 16'd8;
	localparam logic [7:0]  FIRST_CODE  = 8'd32;

	// Commands
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_CURSOR = 2'd1;
	localparam logic [1:0] CMD_DRAW   = 2'd2;

	// Configuration register indexes
	localparam logic REG_DRAW_COLOR = 1'b0;
	localparam logic REG_ROTATION   = 1'b1;

	// Rotation / pixel step codes
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// Sequencer states: each read state consumes the previous read and issues the next
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EN,
		ST_HGT,
		ST_WID,
		ST_OFL,
		ST_OFH,
		ST_ROW
	} state_t;

endpackage

@@ hw/rtl/rotated_bitmap_glyph_renderer_unit.sv @@
// Top level of the rotated bitmap glyph renderer: font memory, cursor and row sequencer.
// Depends on rbgr_pkg.
//
// Channel   Direction  Handshake            Payload
// command   in         start & !busy        cmd, font_addr, font_byte, set_x, set_y, char_code
// config    in         cfg_we               cfg_index, cfg_wdata
// row word  out        strobe (one cycle)   row_x, row_y, row_mask, row_length, direction,
//                                           pixel_color, last_row
//
// Font write and set cursor never raise busy. A draw reads the enable byte (nonzero ends
// it), the height, the glyph entry's width and offset bytes, then the bitmap row by row,
// one byte at a time through the single read port of the font memory. Each row word shows
// on strobe for one cycle; the receiver cannot stall it. Reset clears cursor, color and
// rotation; font memory contents are undefined until written.
`timescale 1ns / 1ps

module rotated_bitmap_glyph_renderer_unit #(
	parameter int FONT_BYTES = rbgr_pkg::FONT_BYTES_DEF,
	parameter int MAX_WIDTH  = rbgr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rbgr_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [11:0] font_addr,
	input  logic [7:0]  font_byte,
	input  logic [15:0] set_x,
	input  logic [15:0] set_y,
	input  logic [7:0]  char_code,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	output logic        strobe,
	output logic [15:0] row_x,
	output logic [15:0] row_y,
	output logic [31:0] row_mask,
	output logic [5:0]  row_length,
	output logic [1:0]  direction,
	output logic [15:0] pixel_color,
	output logic        last_row
);

	localparam int AW    = $clog2(FONT_BYTES);
	localparam int LIM_W = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
	localparam int LIM_H = (MAX_HEIGHT < 32) ? MAX_HEIGHT : 32;

	rbgr_pkg::state_t state_q, state_d;

	logic [7:0]  font_mem_q [FONT_BYTES];
	logic [7:0]  rd_data_s1;
	logic        rd_oor_s1;
	logic [15:0] rd_addr;
	logic [7:0]  rd_byte;
	logic        mem_we;
	logic [15:0] wr_addr;

	logic [15:0] cursor_x_q, cursor_y_q;
	logic [15:0] color_q;
	logic [1:0]  rot_q;
	logic [7:0]  char_q;
	logic [5:0]  height_q, width_q;
	logic [2:0]  stride_q;
	logic [31:0] wmask_q;
	logic [7:0]  off_lo_q;
	logic [15:0] row_base_q;
	logic [1:0]  k_q;
	logic [4:0]  row_q;
	logic [31:0] mask_q;

	logic        accept;
	logic [7:0]  code_n;
	logic [15:0] entry;
	logic        byte_last, row_last, empty, cursor_adv;
	logic [5:0]  width_clip, height_clip;
	logic [31:0] mask_next;
	logic [15:0] row_off;
	logic [15:0] row_x_d, row_y_d;

	assign accept  = start && !busy;
	assign busy    = (state_q != rbgr_pkg::ST_IDLE);
	assign rd_byte = rd_oor_s1 ? 8'd0 : rd_data_s1;
	assign code_n  = char_q - rbgr_pkg::FIRST_CODE;
	assign entry   = rbgr_pkg::ADDR_TABLE + {6'b0, code_n, 2'b00};
	assign byte_last = ({1'b0, k_q} == (stride_q - 3'd1));
	assign row_last  = (({1'b0, row_q} + 6'd1) == height_q);
	assign empty     = (width_q == 6'd0) || (height_q == 6'd0);
	assign cursor_adv = ((state_q == rbgr_pkg::ST_OFH) && empty)
		|| ((state_q == rbgr_pkg::ST_ROW) && byte_last && row_last);
	assign width_clip  = ({24'b0, rd_byte} > 32'(LIM_W)) ? 6'(LIM_W) : rd_byte[5:0];
	assign height_clip = ({24'b0, rd_byte} > 32'(LIM_H)) ? 6'(LIM_H) : rd_byte[5:0];
	assign mask_next = mask_q | ({24'b0, rd_byte} << {k_q, 3'b000});
	assign row_off   = {11'b0, row_q};

	// Font memory write: only from an accepted write command inside the memory
	assign wr_addr = {4'b0, font_addr};
	assign mem_we  = accept && (cmd == rbgr_pkg::CMD_WRITE)
		&& ({1'b0, wr_addr} < 17'(FONT_BYTES));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rbgr_pkg::ST_IDLE: begin
				if (accept && (cmd == rbgr_pkg::CMD_DRAW)) begin
					state_d = rbgr_pkg::ST_EN;
				end
			end
			rbgr_pkg::ST_EN: begin
				state_d = (rd_byte != 8'd0) ? rbgr_pkg::ST_IDLE : rbgr_pkg::ST_HGT;
			end
			rbgr_pkg::ST_HGT: state_d = rbgr_pkg::ST_WID;
			rbgr_pkg::ST_WID: state_d = rbgr_pkg::ST_OFL;
			rbgr_pkg::ST_OFL: state_d = rbgr_pkg::ST_OFH;
			rbgr_pkg::ST_OFH: begin
				state_d = empty ? rbgr_pkg::ST_IDLE : rbgr_pkg::ST_ROW;
			end
			rbgr_pkg::ST_ROW: begin
				if (byte_last && row_last) begin
					state_d = rbgr_pkg::ST_IDLE;
				end
			end
			default: state_d = rbgr_pkg::ST_IDLE;
		endcase
	end

	// Read address issued in each state; data returns in the next state
	always_comb begin
		case (state_q)
			rbgr_pkg::ST_IDLE: rd_addr = rbgr_pkg::ADDR_ENABLE;
			rbgr_pkg::ST_EN:   rd_addr = rbgr_pkg::ADDR_HEIGHT;
			rbgr_pkg::ST_HGT:  rd_addr = entry;
			rbgr_pkg::ST_WID:  rd_addr = entry + 16'd1;
			rbgr_pkg::ST_OFL:  rd_addr = entry + 16'd2;
			rbgr_pkg::ST_OFH:  rd_addr = {rd_byte, off_lo_q};
			rbgr_pkg::ST_ROW: begin
				rd_addr = byte_last ? (row_base_q + {13'b0, stride_q})
					: (row_base_q + {14'b0, k_q} + 16'd1);
			end
			default: rd_addr = rbgr_pkg::ADDR_ENABLE;
		endcase
	end

	// Font memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			font_mem_q[wr_addr[AW-1:0]] <= font_byte;
		end
		rd_data_s1 <= font_mem_q[rd_addr[AW-1:0]];
		rd_oor_s1  <= ({1'b0, rd_addr} >= 17'(FONT_BYTES));
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbgr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= 16'd0;
			rot_q   <= rbgr_pkg::ROT_0;
		end else if (cfg_we) begin
			if (cfg_index == rbgr_pkg::REG_DRAW_COLOR) begin
				color_q <= cfg_wdata;
			end else begin
				rot_q <= cfg_wdata[1:0];
			end
		end
	end

	// Cursor: set directly, or advance by the glyph width after a draw
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= 16'd0;
			cursor_y_q <= 16'd0;
		end else if (accept && (cmd == rbgr_pkg::CMD_CURSOR)) begin
			cursor_x_q <= set_x;
			cursor_y_q <= set_y;
		end else if (cursor_adv) begin
			case (rot_q)
				rbgr_pkg::ROT_0:   cursor_x_q <= cursor_x_q + {10'b0, width_q};
				rbgr_pkg::ROT_90:  cursor_y_q <= cursor_y_q + {10'b0, width_q};
				rbgr_pkg::ROT_180: cursor_x_q <= cursor_x_q - {10'b0, width_q};
				rbgr_pkg::ROT_270: cursor_y_q <= cursor_y_q - {10'b0, width_q};
				default:           cursor_x_q <= cursor_x_q;
			endcase
		end
	end

	// Glyph header and row assembly
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= char_code;
		end
		case (state_q)
			rbgr_pkg::ST_HGT: height_q <= height_clip;
			rbgr_pkg::ST_WID: begin
				width_q  <= width_clip;
				stride_q <= 3'((({26'b0, width_clip} + 32'd7) >> 3));
				wmask_q  <= (width_clip == 6'd32) ? 32'hFFFF_FFFF
					: ((32'd1 << width_clip) - 32'd1);
			end
			rbgr_pkg::ST_OFL: off_lo_q <= rd_byte;
			rbgr_pkg::ST_OFH: begin
				row_base_q <= {rd_byte, off_lo_q};
				k_q        <= 2'd0;
				row_q      <= 5'd0;
				mask_q     <= 32'd0;
			end
			rbgr_pkg::ST_ROW: begin
				if (byte_last) begin
					row_base_q <= row_base_q + {13'b0, stride_q};
					k_q        <= 2'd0;
					row_q      <= row_q + 5'd1;
					mask_q     <= 32'd0;
				end else begin
					k_q    <= k_q + 2'd1;
					mask_q <= mask_next;
				end
			end
			default: k_q <= k_q;
		endcase
	end

	// Row word strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= (state_q == rbgr_pkg::ST_ROW) && byte_last;
		end
	end

	// Place the row start by rotation
	always_comb begin
		row_x_d = cursor_x_q;
		row_y_d = cursor_y_q;
		case (rot_q)
			rbgr_pkg::ROT_0:   row_y_d = cursor_y_q + row_off;
			rbgr_pkg::ROT_90:  row_x_d = cursor_x_q - row_off;
			rbgr_pkg::ROT_180: row_y_d = cursor_y_q - row_off;
			rbgr_pkg::ROT_270: row_x_d = cursor_x_q + row_off;
			default:           row_x_d = cursor_x_q;
		endcase
	end

	// Row word payload
	always_ff @(posedge clk) begin
		if ((state_q == rbgr_pkg::ST_ROW) && byte_last) begin
			row_mask    <= mask_next & wmask_q;
			row_length  <= width_q;
			direction   <= rot_q;
			pixel_color <= color_q;
			last_row    <= row_last;
			row_x       <= row_x_d;
			row_y       <= row_y_d;
		end
	end

	// Checks
	a_strobe_from_row: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == rbgr_pkg::ST_ROW))
		else $error("row word without a row read");

	a_last_row_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_row) |-> !busy)
		else $error("sequencer still busy after last row");

	a_idle_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !strobe)
		else $error("row word after idle cycle");

	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> ($stable(cursor_x_q) && $stable(cursor_y_q)))
		else $error("cursor moved during a draw");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the rotated bitmap glyph renderer: loads font bytes, moves
// the cursor and draws glyphs under all rotations, checking every row word against a predictor.
// Depends on rbgr_pkg and rotated_bitmap_glyph_renderer_unit.
`timescale 1ns / 1ps

module tb;

	localparam int FONT_BYTES    = rbgr_pkg::FONT_BYTES_DEF;
	localparam int LIM_W         = (rbgr_pkg::MAX_WIDTH_DEF < 32) ? rbgr_pkg::MAX_WIDTH_DEF : 32;
	localparam int LIM_H         = (rbgr_pkg::MAX_HEIGHT_DEF < 32)
		? rbgr_pkg::MAX_HEIGHT_DEF : 32;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RAND_PHASES   = 8;
	localparam int PHASE_ITEMS   = 26;
	localparam int QUIET_AFTER   = 240;
	localparam int SETTLE_CYCLES = 140;
	localparam int STALL_LIMIT   = 2000;

	typedef struct packed {
		logic [15:0] row_x;
		logic [15:0] row_y;
		logic [31:0] row_mask;
		logic [5:0]  row_length;
		logic [1:0]  direction;
		logic [15:0] pixel_color;
		logic        last_row;
	} glyph_row_t;

	// Font image, cursor and registers; predicts the row words of each draw
	class glyph_scoreboard;
		bit [7:0]   font_mem [FONT_BYTES];
		bit         font_known [FONT_BYTES];
		bit [15:0]  cur_x;
		bit [15:0]  cur_y;
		bit [15:0]  color;
		bit [1:0]   rot;
		glyph_row_t pending [$];
		int         errors;

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		function bit [7:0] font_rd(int unsigned addr);
			addr = addr & 32'hFFFF;
			if (addr >= FONT_BYTES)
				return 8'h00;
			return font_mem[addr];
		endfunction

		function int unsigned entry_addr(bit [7:0] code);
			return rbgr_pkg::ADDR_TABLE + 4 * ((code - rbgr_pkg::FIRST_CODE) & 8'hFF);
		endfunction

		// Queue one word per glyph row, then advance the cursor along the text direction; a disabled font does neither
		function void render(bit [7:0] code);
			int unsigned ea, wid, hgt, offs, stride, base, r, i;
			bit [7:0] b;
			glyph_row_t rw;
			if (font_rd(rbgr_pkg::ADDR_ENABLE) != 8'h00)
				return;
			ea = entry_addr(code);
			wid = font_rd(ea);
			offs = {font_rd(ea + 2), font_rd(ea + 1)};
			hgt = font_rd(rbgr_pkg::ADDR_HEIGHT);
			if (wid > LIM_W)
				wid = LIM_W;
			if (hgt > LIM_H)
				hgt = LIM_H;
			stride = (wid + 7) / 8;
			if (wid != 0) begin
				for (r = 0; r < hgt; r++) begin
					rw.row_mask = '0;
					base = offs + r * stride;
					for (i = 0; i < wid; i++) begin
						b = font_rd(base + i / 8);
						if (b[i % 8])
							rw.row_mask[i] = 1'b1;
					end
					rw.row_x = cur_x;
					rw.row_y = cur_y;
					case (rot)
						rbgr_pkg::ROT_0:   rw.row_y = cur_y + 16'(r);
						rbgr_pkg::ROT_90:  rw.row_x = cur_x - 16'(r);
						rbgr_pkg::ROT_180: rw.row_y = cur_y - 16'(r);
						default:           rw.row_x = cur_x + 16'(r);
					endcase
					rw.row_length = 6'(wid);
					rw.direction = rot;
					rw.pixel_color = color;
					rw.last_row = (r + 1 == hgt);
					pending.push_back(rw);
				end
			end
			case (rot)
				rbgr_pkg::ROT_0:   cur_x = cur_x + 16'(wid);
				rbgr_pkg::ROT_90:  cur_y = cur_y + 16'(wid);
				rbgr_pkg::ROT_180: cur_x = cur_x - 16'(wid);
				default:           cur_y = cur_y - 16'(wid);
			endcase
		endfunction

		function void note_command(bit [1:0] c, bit [11:0] a, bit [7:0] d, bit [15:0] x,
				bit [15:0] y, bit [7:0] ch);
			case (c)
				rbgr_pkg::CMD_WRITE: begin
					if (a < FONT_BYTES) begin
						font_mem[a] = d;
						font_known[a] = 1'b1;
					end
				end
				rbgr_pkg::CMD_CURSOR: begin
					cur_x = x;
					cur_y = y;
				end
				rbgr_pkg::CMD_DRAW: render(ch);
				default: ;
			endcase
		endfunction

		function void set_reg(bit idx, bit [15:0] v);
			if (idx == rbgr_pkg::REG_DRAW_COLOR)
				color = v;
			else
				rot = v[1:0];
		endfunction

		task compare_field(string name, bit [31:0] got, bit [31:0] want);
			if (got != want)
				report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_row(glyph_row_t got);
			glyph_row_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("row word %h with no draw pending", got));
				return;
			end
			want = pending.pop_front();
			compare_field("row_x", got.row_x, want.row_x);
			compare_field("row_y", got.row_y, want.row_y);
			compare_field("row_mask", got.row_mask, want.row_mask);
			compare_field("row_length", got.row_length, want.row_length);
			compare_field("direction", got.direction, want.direction);
			compare_field("pixel_color", got.pixel_color, want.pixel_color);
			compare_field("last_row", got.last_row, want.last_row);
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = rbgr_pkg::CMD_WRITE;
	logic [11:0] font_addr = '0;
	logic [7:0]  font_byte = '0;
	logic [15:0] set_x = '0;
	logic [15:0] set_y = '0;
	logic [7:0]  char_code = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = rbgr_pkg::REG_DRAW_COLOR;
	logic [15:0] cfg_wdata = '0;
	logic        strobe;
	logic [15:0] row_x;
	logic [15:0] row_y;
	logic [31:0] row_mask;
	logic [5:0]  row_length;
	logic [1:0]  direction;
	logic [15:0] pixel_color;
	logic        last_row;

	glyph_scoreboard sb;
	int items_sent = 0;
	bit idle_on = 1'b1;
	int stall_cycles = 0;

	rotated_bitmap_glyph_renderer_unit #(
		.FONT_BYTES(rbgr_pkg::FONT_BYTES_DEF),
		.MAX_WIDTH(rbgr_pkg::MAX_WIDTH_DEF),
		.MAX_HEIGHT(rbgr_pkg::MAX_HEIGHT_DEF)
	) dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Check each row word in the cycle it is strobed
	always @(posedge clk) begin : row_monitor
		glyph_row_t got;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			got = {row_x, row_y, row_mask, row_length, direction, pixel_color, last_row};
			sb.check_row(got);
		end
	end

	// End the run if neither side moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || cfg_we)
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Present one command word, hold it until accepted, then log it
	task automatic send(bit [1:0] c, bit [11:0] a, bit [7:0] d, bit [15:0] x, bit [15:0] y,
			bit [7:0] ch);
		if (idle_on && items_sent < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		font_addr <= a;
		font_byte <= d;
		set_x <= x;
		set_y <= y;
		char_code <= ch;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_command(c, a, d, x, y, ch);
		items_sent++;
	endtask

	task automatic send_unused();
		send(CMD_UNUSED, 12'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom));
	endtask

	task automatic write_byte(bit [11:0] a, bit [7:0] d);
		send(rbgr_pkg::CMD_WRITE, a, d, 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	task automatic set_cursor(bit [15:0] x, bit [15:0] y);
		send(rbgr_pkg::CMD_CURSOR, 12'($urandom), 8'($urandom), x, y, 8'($urandom));
	endtask

	task automatic define_glyph(bit [7:0] code, bit [7:0] wid, bit [15:0] offs);
		int unsigned ea;
		ea = sb.entry_addr(code);
		write_byte(12'(ea), wid);
		write_byte(12'(ea + 1), offs[7:0]);
		write_byte(12'(ea + 2), offs[15:8]);
	endtask

	// Write every font byte the draw will read that has never been written
	task automatic ready_glyph(bit [7:0] code);
		int unsigned ea, wid, hgt, offs, stride, a, r, k;
		ea = sb.entry_addr(code);
		if (!sb.font_known[rbgr_pkg::ADDR_ENABLE])
			write_byte(12'(rbgr_pkg::ADDR_ENABLE), 8'h00);
		if (!sb.font_known[rbgr_pkg::ADDR_HEIGHT])
			write_byte(12'(rbgr_pkg::ADDR_HEIGHT), 8'($urandom_range(1, 4)));
		if (!sb.font_known[ea])
			write_byte(12'(ea), 8'($urandom_range(0, 12)));
		if (!sb.font_known[ea + 1])
			write_byte(12'(ea + 1), 8'($urandom));
		if (!sb.font_known[ea + 2])
			write_byte(12'(ea + 2), 8'($urandom_range(0, 15)));
		if (sb.font_mem[rbgr_pkg::ADDR_ENABLE] != 8'h00)
			return;
		wid = sb.font_mem[ea];
		hgt = sb.font_mem[rbgr_pkg::ADDR_HEIGHT];
		offs = {sb.font_mem[ea + 2], sb.font_mem[ea + 1]};
		if (wid > LIM_W)
			wid = LIM_W;
		if (hgt > LIM_H)
			hgt = LIM_H;
		stride = (wid + 7) / 8;
		for (r = 0; r < hgt; r++) begin
			for (k = 0; k < stride; k++) begin
				a = (offs + r * stride + k) & 32'hFFFF;
				if (a < FONT_BYTES && !sb.font_known[a])
					write_byte(12'(a), 8'($urandom));
			end
		end
	endtask

	task automatic draw_char(bit [7:0] code);
		ready_glyph(code);
		send(rbgr_pkg::CMD_DRAW, 12'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
			code);
	endtask

	// Hold off the sender until all rows are out and the block has gone quiet
	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(bit [15:0] color, bit [1:0] rot);
		bit [15:0] rot_word;
		rot_word = 16'($urandom);
		rot_word[1:0] = rot;
		drain();
		cfg_we <= 1'b1;
		cfg_index <= rbgr_pkg::REG_DRAW_COLOR;
		cfg_wdata <= color;
		@(posedge clk);
		sb.set_reg(rbgr_pkg::REG_DRAW_COLOR, color);
		cfg_index <= rbgr_pkg::REG_ROTATION;
		cfg_wdata <= rot_word;
		@(posedge clk);
		sb.set_reg(rbgr_pkg::REG_ROTATION, rot_word);
		cfg_we <= 1'b0;
	endtask

	task automatic directed_part();
		bit [7:0] pattern [4] = '{8'hFF, 8'h01, 8'h80, 8'h00};
		int k;
		write_byte(12'(rbgr_pkg::ADDR_ENABLE), 8'h00);
		write_byte(12'(rbgr_pkg::ADDR_HEIGHT), 8'd1);
		// widest glyph on the first table entry, mixed bit patterns
		define_glyph(rbgr_pkg::FIRST_CODE, 8'd32, 16'h0100);
		for (k = 0; k < 4; k++)
			write_byte(12'h100 + 12'(k), pattern[k]);
		// start from the far corner so the cursor wraps
		set_cursor(16'hFFFF, 16'hFFFF);
		draw_char(rbgr_pkg::FIRST_CODE);
		// code below the table start hits the last entry; width gets clipped
		define_glyph(rbgr_pkg::FIRST_CODE - 8'd1, 8'd40, 16'h0100);
		draw_char(rbgr_pkg::FIRST_CODE - 8'd1);
		// row that runs off the 16-bit address space and wraps to zero
		define_glyph(8'd34, 8'd24, 16'hFFFE);
		draw_char(8'd34);
		// zero height: no rows but the cursor still moves
		write_byte(12'(rbgr_pkg::ADDR_HEIGHT), 8'd0);
		draw_char(rbgr_pkg::FIRST_CODE);
		// oversized height with the bitmap beyond the font memory
		write_byte(12'(rbgr_pkg::ADDR_HEIGHT), 8'hFF);
		define_glyph(8'd33, 8'd9, 16'h1000);
		draw_char(8'd33);
		write_byte(12'(rbgr_pkg::ADDR_HEIGHT), 8'd2);
		// font disabled: no rows, cursor held
		write_byte(12'(rbgr_pkg::ADDR_ENABLE), 8'h80);
		draw_char(rbgr_pkg::FIRST_CODE);
		write_byte(12'(rbgr_pkg::ADDR_ENABLE), 8'h00);
		send_unused();
		// top character code with its bitmap starting at the last font byte
		define_glyph(8'hFF, 8'd1, 16'h0FFF);
		draw_char(8'hFF);
	endtask

	// Mostly define-and-draw sequences, with noise, disabled draws and unused commands
	task automatic random_sequence();
		bit [7:0] code;
		int unsigned sel, wid, hgt, offs;
		sel = $urandom_range(0, 9);
		idle_on = ($urandom_range(0, 2) != 0);
		if (sel < 6) begin
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 19))
					0:       hgt = 0;
					1:       hgt = $urandom_range(33, 255);
					2, 3:    hgt = $urandom_range(6, 32);
					default: hgt = $urandom_range(1, 5);
				endcase
				write_byte(12'(rbgr_pkg::ADDR_HEIGHT), 8'(hgt));
			end
			case ($urandom_range(0, 9))
				0:       wid = 0;
				1:       wid = $urandom_range(17, 32);
				2:       wid = $urandom_range(33, 255);
				default: wid = $urandom_range(1, 16);
			endcase
			case ($urandom_range(0, 9))
				0:       offs = $urandom_range(FONT_BYTES, 16'hFFFF);
				1:       offs = $urandom_range(16'hFFF0, 16'hFFFF);
				default: offs = $urandom_range(0, FONT_BYTES - 1);
			endcase
			code = 8'($urandom);
			define_glyph(code, 8'(wid), 16'(offs));
			if ($urandom_range(0, 1) == 0)
				set_cursor(16'($urandom), 16'($urandom));
			repeat ($urandom_range(1, 3)) draw_char(code);
		end else if (sel == 6) begin
			write_byte(12'($urandom), 8'($urandom));
		end else if (sel == 7) begin
			write_byte(12'(rbgr_pkg::ADDR_ENABLE), 8'($urandom_range(1, 255)));
			draw_char(8'($urandom));
			write_byte(12'(rbgr_pkg::ADDR_ENABLE), 8'h00);
		end else if (sel == 8) begin
			set_cursor(16'($urandom), 16'($urandom));
		end else if ($urandom_range(0, 1) == 0) begin
			draw_char(8'($urandom));
		end else begin
			send_unused();
		end
	endtask

	initial begin
		logic [1:0] rot_plan [4];
		bit [15:0] color;
		int ph;
		int phase_end;
		rot_plan = '{rbgr_pkg::ROT_0, rbgr_pkg::ROT_90, rbgr_pkg::ROT_180, rbgr_pkg::ROT_270};
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		configure(16'hFFFF, rbgr_pkg::ROT_0);
		directed_part();
		for (ph = 1; ph <= RAND_PHASES; ph++) begin
			case (ph)
				1:       color = 16'h0000;
				2:       color = 16'hFFFF;
				default: color = 16'($urandom);
			endcase
			configure(color, rot_plan[ph % 4]);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) random_sequence();
		end
		drain();
		if (sb.pending.size() != 0)
			sb.report_mismatch($sformatf("%0d row words never arrived", sb.pending.size()));
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/rbgr_pkg.sv
hw/rtl/rotated_bitmap_glyph_renderer_unit.sv
sim/tb.sv
